// ----- hw/rtl/q2e_pkg.sv -----
// Shared constants, types and tables of the quaternion to Euler angles datapath.
package q2e_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_ITER = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;

   localparam int FRONT_LAT = 3;
   localparam int ISQ_STEPS = 29;
   localparam int CORDIC_LAT = CORDIC_ITER + 3;
   localparam int DIV_LAT = 19;
   localparam int ALIGN_LAT = (CORDIC_LAT > DIV_LAT) ? CORDIC_LAT : DIV_LAT;
   localparam int PIPE_DEPTH = FRONT_LAT + ISQ_STEPS + ALIGN_LAT;

   localparam int RAD_W = 57;
   localparam int ROOT_W = 29;
   localparam int ARG_W = 42;
   localparam int ANG_W = 35;
   localparam int CW = 45;
   localparam int NORM_BIT = 40;
   localparam int QW = 20;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_MARKER = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   localparam logic [RAD_W-1:0] RAD_ONE = 57'h100_0000_0000_0000;
   localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

   localparam logic signed [QW-1:0] ROT_MAX = 20'sd51472;
   localparam logic signed [QW-1:0] YAW_MAX = 20'sd25736;
   localparam logic signed [QW-1:0] PITCH_MAX = 20'sd12868;

   typedef struct packed {
      logic signed [15:0] wc;
      logic signed [29:0] a;
      logic signed [33:0] yaw_y;
      logic signed [33:0] yaw_x;
      logic signed [33:0] roll_y;
      logic signed [33:0] roll_x;
      logic signed [15:0] z;
   } car_type;

   typedef struct packed {
      logic [RAD_W-1:0] n_half;
      logic [RAD_W-1:0] n_pitch;
      car_type car;
   } fr_type;

   typedef struct packed {
      logic zero;
      logic neg;
      logic big;
   } dflag_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         0: r = 35'sd843314856;
         1: r = 35'sd497837829;
         2: r = 35'sd263043836;
         3: r = 35'sd133525158;
         4: r = 35'sd67021686;
         5: r = 35'sd33543515;
         6: r = 35'sd16775850;
         7: r = 35'sd8388437;
         8: r = 35'sd4194282;
         9: r = 35'sd2097149;
         10: r = 35'sd1048575;
         11: r = 35'sd524287;
         12: r = 35'sd262143;
         13: r = 35'sd131071;
         14: r = 35'sd65535;
         15: r = 35'sd32767;
         16: r = 35'sd16383;
         17: r = 35'sd8191;
         18: r = 35'sd4095;
         19: r = 35'sd2047;
         20: r = 35'sd1023;
         21: r = 35'sd511;
         22: r = 35'sd255;
         23: r = 35'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Rounds a Q30 angle to Q13, to nearest with ties upwards.
   function automatic logic signed [QW-1:0] q13_round(input logic signed [ANG_W+1:0] v);
      logic signed [ANG_W+1:0] s;
      s = v + 37'sd65536;
      return s[ANG_W+1:17];
   endfunction

endpackage

// ----- hw/rtl/q2e_if.sv -----
// Request and response channel interfaces of the quaternion to Euler angles block.
interface q2e_req_if;
   logic valid;
   logic ready;
   logic [7:0] marker_count;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, marker_count, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, marker_count, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2e_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] rotation_angle;
   logic signed [15:0] axis_z;
   logic axis_overflow;
   logic signed [15:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] roll_angle;

   modport source (output valid, status, rotation_angle, axis_z, axis_overflow, yaw_angle,
                   pitch_angle, roll_angle, input ready);
   modport sink (input valid, status, rotation_angle, axis_z, axis_overflow, yaw_angle,
                 pitch_angle, roll_angle, output ready);
endinterface

// ----- hw/rtl/q2e_front.sv -----
// Product and sum stages that form the square root radicands and the angle arguments.
module q2e_front (
   input logic clock,
   input logic en,
   input logic signed [15:0] quat_x,
   input logic signed [15:0] quat_y,
   input logic signed [15:0] quat_z,
   input logic signed [15:0] quat_w,
   output q2e_pkg::fr_type fr
);

   logic signed [15:0] wc_in;
   logic signed [31:0] wsq_in;
   logic signed [31:0] xx_in, yy_in, zz_in, ww_in, yz_in, wx_in, xy_in, wz_in, wy_in, xz_in;

   logic signed [15:0] wc1_ff, z1_ff;
   logic [28:0] wsq1_ff;
   logic signed [31:0] xx1_ff, yy1_ff, zz1_ff, ww1_ff, yz1_ff, wx1_ff;
   logic signed [31:0] xy1_ff, wz1_ff, wy1_ff, xz1_ff;

   logic [q2e_pkg::RAD_W-1:0] nh2_in;
   logic signed [33:0] d2_in;
   logic signed [29:0] a2_in;
   q2e_pkg::car_type car2_in;
   logic [q2e_pkg::RAD_W-1:0] nh2_ff;
   q2e_pkg::car_type car2_ff;

   logic signed [59:0] aa_in;
   q2e_pkg::fr_type fr_ff;

   // The half-angle path uses w clamped to one; the angle formulas use it as given.
   always_comb begin
      if (quat_w > 16'sd16384) begin
         wc_in = 16'sd16384;
      end else if (quat_w < -16'sd16384) begin
         wc_in = -16'sd16384;
      end else begin
         wc_in = quat_w;
      end
      wsq_in = wc_in * wc_in;
      xx_in = quat_x * quat_x;
      yy_in = quat_y * quat_y;
      zz_in = quat_z * quat_z;
      ww_in = quat_w * quat_w;
      yz_in = quat_y * quat_z;
      wx_in = quat_w * quat_x;
      xy_in = quat_x * quat_y;
      wz_in = quat_w * quat_z;
      wy_in = quat_w * quat_y;
      xz_in = quat_x * quat_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wc1_ff <= wc_in;
         z1_ff <= quat_z;
         wsq1_ff <= wsq_in[28:0];
         xx1_ff <= xx_in;
         yy1_ff <= yy_in;
         zz1_ff <= zz_in;
         ww1_ff <= ww_in;
         yz1_ff <= yz_in;
         wx1_ff <= wx_in;
         xy1_ff <= xy_in;
         wz1_ff <= wz_in;
         wy1_ff <= wy_in;
         xz1_ff <= xz_in;
      end
   end

   always_comb begin
      nh2_in = q2e_pkg::RAD_ONE - {wsq1_ff, 28'd0};
      car2_in.wc = wc1_ff;
      car2_in.z = z1_ff;
      car2_in.yaw_y = (34'(yz1_ff) + 34'(wx1_ff)) <<< 1;
      car2_in.yaw_x = 34'(ww1_ff) - 34'(xx1_ff) - 34'(yy1_ff) + 34'(zz1_ff);
      car2_in.roll_y = (34'(xy1_ff) + 34'(wz1_ff)) <<< 1;
      car2_in.roll_x = 34'(ww1_ff) + 34'(xx1_ff) - 34'(yy1_ff) - 34'(zz1_ff);
      d2_in = (34'(wy1_ff) - 34'(xz1_ff)) <<< 1;
      if (d2_in > 34'sd268435456) begin
         a2_in = 30'sd268435456;
      end else if (d2_in < -34'sd268435456) begin
         a2_in = -30'sd268435456;
      end else begin
         a2_in = d2_in[29:0];
      end
      car2_in.a = a2_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nh2_ff <= nh2_in;
         car2_ff <= car2_in;
      end
   end

   assign aa_in = car2_ff.a * car2_ff.a;

   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff.n_half <= nh2_ff;
         fr_ff.n_pitch <= q2e_pkg::RAD_ONE - aa_in[q2e_pkg::RAD_W-1:0];
         fr_ff.car <= car2_ff;
      end
   end

   assign fr = fr_ff;

endmodule

// ----- hw/rtl/q2e_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module q2e_isqrt (
   input logic clock,
   input logic en,
   input logic [q2e_pkg::RAD_W-1:0] radicand,
   output logic [q2e_pkg::ROOT_W-1:0] root
);

   localparam int N = q2e_pkg::ISQ_STEPS;
   localparam int W = q2e_pkg::RAD_W + 1;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] res_ff [N];
   logic [W-1:0] rem_in [N];
   logic [W-1:0] res_in [N];

   always_comb begin
      logic [W-1:0] rs, qs, bitv, trial;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            rs = {1'b0, radicand};
            qs = '0;
         end else begin
            rs = rem_ff[k-1];
            qs = res_ff[k-1];
         end
         bitv = W'(1) << (2 * (N - 1 - k));
         trial = qs + bitv;
         if (rs >= trial) begin
            rem_in[k] = rs - trial;
            res_in[k] = (qs >> 1) + bitv;
         end else begin
            rem_in[k] = rs;
            res_in[k] = qs >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[N-1][q2e_pkg::ROOT_W-1:0];

endmodule

// ----- hw/rtl/q2e_div.sv -----
// Pipelined restoring divider for the rotation axis z component, with saturation.
module q2e_div (
   input logic clock,
   input logic en,
   input logic signed [15:0] z,
   input logic [q2e_pkg::ROOT_W-1:0] s28,
   output logic signed [15:0] axis,
   output logic ovf
);

   localparam int QB = 17;
   localparam int RW = 46;
   localparam int PAD = q2e_pkg::ALIGN_LAT - q2e_pkg::DIV_LAT;

   logic signed [16:0] zx_in;
   logic [16:0] mag_in;
   logic [43:0] num_in;
   q2e_pkg::dflag_type fl_in;

   logic [RW-1:0] rem_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic [q2e_pkg::ROOT_W-1:0] den_ff [QB+1];
   q2e_pkg::dflag_type fl_ff [QB+1];

   logic [RW-1:0] rem_in [QB];
   logic [QB-1:0] quo_in [QB];

   logic signed [15:0] axis_in, axis_ff;
   logic ovf_in, ovf_ff;

   // The quotient is rounded by adding half the divisor to the dividend.
   always_comb begin
      zx_in = 17'(z);
      mag_in = zx_in[16] ? 17'(-zx_in) : 17'(zx_in);
      num_in = {mag_in[15:0], s28[q2e_pkg::ROOT_W-1:1]};
      fl_in.zero = (s28 == '0);
      fl_in.neg = z[15];
      fl_in.big = ({2'b00, num_in} >= {s28, 17'd0});
   end

   always_comb begin
      logic [RW-1:0] dsh;
      for (int k = 0; k < QB; k++) begin
         dsh = RW'(den_ff[k]) << (QB - 1 - k);
         if (rem_ff[k] >= dsh) begin
            rem_in[k] = rem_ff[k] - dsh;
            quo_in[k] = quo_ff[k] | (QB'(1) << (QB - 1 - k));
         end else begin
            rem_in[k] = rem_ff[k];
            quo_in[k] = quo_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {2'b00, num_in};
         quo_ff[0] <= '0;
         den_ff[0] <= s28;
         fl_ff[0] <= fl_in;
         for (int k = 0; k < QB; k++) begin
            rem_ff[k+1] <= rem_in[k];
            quo_ff[k+1] <= quo_in[k];
            den_ff[k+1] <= den_ff[k];
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   always_comb begin
      ovf_in = 1'b0;
      axis_in = '0;
      if (fl_ff[QB].zero || fl_ff[QB].big) begin
         ovf_in = 1'b1;
         axis_in = fl_ff[QB].neg ? -16'sd32768 : 16'sd32767;
      end else if (fl_ff[QB].neg) begin
         if (quo_ff[QB] > 17'd32768) begin
            ovf_in = 1'b1;
            axis_in = -16'sd32768;
         end else begin
            axis_in = 16'(17'd0 - quo_ff[QB]);
         end
      end else begin
         if (quo_ff[QB] > 17'd32767) begin
            ovf_in = 1'b1;
            axis_in = 16'sd32767;
         end else begin
            axis_in = 16'(quo_ff[QB]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axis_ff <= axis_in;
         ovf_ff <= ovf_in;
      end
   end

   generate
      if (PAD == 0) begin : g_nopad
         assign axis = axis_ff;
         assign ovf = ovf_ff;
      end else begin : g_pad
         logic signed [15:0] paxis_ff [PAD];
         logic povf_ff [PAD];
         always_ff @(posedge clock) begin
            if (en) begin
               paxis_ff[0] <= axis_ff;
               povf_ff[0] <= ovf_ff;
               for (int p = 1; p < PAD; p++) begin
                  paxis_ff[p] <= paxis_ff[p-1];
                  povf_ff[p] <= povf_ff[p-1];
               end
            end
         end
         assign axis = paxis_ff[PAD-1];
         assign ovf = povf_ff[PAD-1];
      end
   endgenerate

endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// Pipelined vectoring CORDIC giving atan2 in Q30 radians.
module q2e_cordic (
   input logic clock,
   input logic en,
   input logic signed [q2e_pkg::ARG_W-1:0] y_arg,
   input logic signed [q2e_pkg::ARG_W-1:0] x_arg,
   output logic signed [q2e_pkg::ANG_W-1:0] angle
);

   localparam int CW = q2e_pkg::CW;
   localparam int AW = q2e_pkg::ANG_W;
   localparam int N = q2e_pkg::CORDIC_ITER;
   localparam int PAD = q2e_pkg::ALIGN_LAT - q2e_pkg::CORDIC_LAT;

   logic signed [CW-1:0] x0_in, y0_in, x0_ff, y0_ff;
   logic [CW-1:0] mag0_in, mag0_ff;
   logic signed [AW-1:0] base0_in, base0_ff;
   logic spec0_in, spec0_ff;

   logic [5:0] msb1;
   logic [5:0] shift1_in, shift1_ff;
   logic signed [CW-1:0] x1_ff, y1_ff;
   logic signed [AW-1:0] base1_ff;
   logic spec1_ff;

   logic signed [CW-1:0] xs_ff [N+1];
   logic signed [CW-1:0] ys_ff [N+1];
   logic signed [AW-1:0] acc_ff [N+1];
   logic sp_ff [N+1];
   logic signed [CW-1:0] xs_in [N];
   logic signed [CW-1:0] ys_in [N];
   logic signed [AW-1:0] acc_in [N];

   // Axis cases are answered directly; a negative x is mirrored and offset by pi.
   always_comb begin
      spec0_in = 1'b0;
      base0_in = '0;
      x0_in = CW'(x_arg);
      y0_in = CW'(y_arg);
      if (y_arg == '0) begin
         spec0_in = 1'b1;
         base0_in = (x_arg < 0) ? q2e_pkg::PI_Q30 : '0;
      end else if (x_arg == '0) begin
         spec0_in = 1'b1;
         base0_in = (y_arg > 0) ? q2e_pkg::HALF_PI_Q30 : -q2e_pkg::HALF_PI_Q30;
      end else if (x_arg < 0) begin
         base0_in = (y_arg > 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
         x0_in = -CW'(x_arg);
         y0_in = -CW'(y_arg);
      end
      mag0_in = x0_in | (y0_in[CW-1] ? -y0_in : y0_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         mag0_ff <= mag0_in;
         base0_ff <= base0_in;
         spec0_ff <= spec0_in;
      end
   end

   // Normalise so that the larger of |x| and |y| reaches the reference bit.
   always_comb begin
      msb1 = '0;
      for (int b = 0; b < CW; b++) begin
         if (mag0_ff[b]) begin
            msb1 = 6'(b);
         end
      end
      shift1_in = (msb1 >= 6'(q2e_pkg::NORM_BIT)) ? '0 : 6'(q2e_pkg::NORM_BIT) - msb1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x0_ff;
         y1_ff <= y0_ff;
         shift1_ff <= shift1_in;
         base1_ff <= base0_ff;
         spec1_ff <= spec0_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (sp_ff[k]) begin
            xs_in[k] = xs_ff[k];
            ys_in[k] = ys_ff[k];
            acc_in[k] = acc_ff[k];
         end else if (ys_ff[k] > 0) begin
            xs_in[k] = xs_ff[k] + (ys_ff[k] >>> k);
            ys_in[k] = ys_ff[k] - (xs_ff[k] >>> k);
            acc_in[k] = acc_ff[k] + q2e_pkg::atan_q30(k);
         end else begin
            xs_in[k] = xs_ff[k] - (ys_ff[k] >>> k);
            ys_in[k] = ys_ff[k] + (xs_ff[k] >>> k);
            acc_in[k] = acc_ff[k] - q2e_pkg::atan_q30(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff[0] <= x1_ff <<< shift1_ff;
         ys_ff[0] <= y1_ff <<< shift1_ff;
         acc_ff[0] <= base1_ff;
         sp_ff[0] <= spec1_ff;
         for (int k = 0; k < N; k++) begin
            xs_ff[k+1] <= xs_in[k];
            ys_ff[k+1] <= ys_in[k];
            acc_ff[k+1] <= acc_in[k];
            sp_ff[k+1] <= sp_ff[k];
         end
      end
   end

   generate
      if (PAD == 0) begin : g_nopad
         assign angle = acc_ff[N];
      end else begin : g_pad
         logic signed [AW-1:0] pang_ff [PAD];
         always_ff @(posedge clock) begin
            if (en) begin
               pang_ff[0] <= acc_ff[N];
               for (int p = 1; p < PAD; p++) begin
                  pang_ff[p] <= pang_ff[p-1];
               end
            end
         end
         assign angle = pang_ff[PAD-1];
      end
   endgenerate

endmodule

// ----- hw/rtl/quaternion_to_euler_angles_core.sv -----
// Top level of the quaternion to Euler angles block: pipeline control and result stage.
//
// A request carries a marker count and one orientation quaternion in signed Q2.14. Each
// request gives exactly one response, in request order. For a count of one or two the
// response holds the rotation angle 2*acos(w), the axis z component z/sin(acos(w)) with
// its overflow flag, the yaw and roll angles in Q3.13 radians and the pitch angle in Q2.13
// radians. A count of zero answers "no marker", a count above two answers "ignored"; all
// other fields are then zero. The block keeps no state between requests, so a new request
// may enter every cycle while responses are taken. The path has three product and sum
// stages, 29 square root stages (one root bit each), the longer of the CORDIC pipeline
// (three set-up stages plus one per iteration) and the 19-stage divider, and the output
// register. Throughput is one request per cycle while responses are taken.
// All stages advance together. When the receiver holds off, the output register keeps
// its response and the pipeline freezes, so nothing is lost or repeated; a request is
// still accepted in any cycle in which the output register is empty or being emptied.
// Synchronous reset clears every valid bit; the datapath registers are not reset.
module quaternion_to_euler_angles_core (
   input logic clock,
   input logic reset,
   q2e_req_if.sink req_bus,
   q2e_rsp_if.source rsp_bus
);

   localparam int DEPTH = q2e_pkg::PIPE_DEPTH;
   localparam int NS = q2e_pkg::ISQ_STEPS;

   logic en;
   logic [1:0] status_in;

   logic mvalid_ff [DEPTH];
   logic [1:0] mstat_ff [DEPTH];

   q2e_pkg::fr_type fr;
   q2e_pkg::car_type car_ff [NS];
   q2e_pkg::car_type car;

   logic [q2e_pkg::ROOT_W-1:0] s28, cpitch;
   logic signed [q2e_pkg::ANG_W-1:0] half_ang, yaw_ang, pitch_ang, roll_ang;
   logic signed [15:0] axis_val;
   logic axis_ovf;

   logic signed [q2e_pkg::QW-1:0] rot_r, yaw_r, pitch_r, roll_r;
   logic [15:0] rot_in;
   logic signed [15:0] yaw_in, roll_in;
   logic signed [14:0] pitch_in;

   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic [15:0] rot_ff;
   logic signed [15:0] axis_ff;
   logic ovf_ff;
   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;

   // The whole pipeline moves when the output register can take a new response.
   assign en = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   always_comb begin
      if (req_bus.marker_count == 8'd0) begin
         status_in = q2e_pkg::STATUS_NO_MARKER;
      end else if (req_bus.marker_count > 8'd2) begin
         status_in = q2e_pkg::STATUS_IGNORED;
      end else begin
         status_in = q2e_pkg::STATUS_OK;
      end
   end

   // Valid bits and status travel alongside the datapath, one entry per stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            mvalid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         mvalid_ff[0] <= req_bus.valid;
         for (int i = 1; i < DEPTH; i++) begin
            mvalid_ff[i] <= mvalid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mstat_ff[0] <= status_in;
         for (int i = 1; i < DEPTH; i++) begin
            mstat_ff[i] <= mstat_ff[i-1];
         end
      end
   end

   q2e_front u_front (
      .clock (clock),
      .en (en),
      .quat_x (req_bus.quat_x),
      .quat_y (req_bus.quat_y),
      .quat_z (req_bus.quat_z),
      .quat_w (req_bus.quat_w),
      .fr (fr)
   );

   // The angle arguments wait here while the square roots are worked out.
   always_ff @(posedge clock) begin
      if (en) begin
         car_ff[0] <= fr.car;
         for (int i = 1; i < NS; i++) begin
            car_ff[i] <= car_ff[i-1];
         end
      end
   end

   assign car = car_ff[NS-1];

   q2e_isqrt u_isqrt_half (
      .clock (clock),
      .en (en),
      .radicand (fr.n_half),
      .root (s28)
   );

   q2e_isqrt u_isqrt_pitch (
      .clock (clock),
      .en (en),
      .radicand (fr.n_pitch),
      .root (cpitch)
   );

   // Half the rotation angle is atan2(sqrt(1 - w^2), w) with w in Q28.
   q2e_cordic u_cordic_half (
      .clock (clock),
      .en (en),
      .y_arg (q2e_pkg::ARG_W'(s28)),
      .x_arg (q2e_pkg::ARG_W'(car.wc) <<< 14),
      .angle (half_ang)
   );

   q2e_cordic u_cordic_yaw (
      .clock (clock),
      .en (en),
      .y_arg (q2e_pkg::ARG_W'(car.yaw_y)),
      .x_arg (q2e_pkg::ARG_W'(car.yaw_x)),
      .angle (yaw_ang)
   );

   q2e_cordic u_cordic_pitch (
      .clock (clock),
      .en (en),
      .y_arg (q2e_pkg::ARG_W'(car.a)),
      .x_arg (q2e_pkg::ARG_W'(cpitch)),
      .angle (pitch_ang)
   );

   q2e_cordic u_cordic_roll (
      .clock (clock),
      .en (en),
      .y_arg (q2e_pkg::ARG_W'(car.roll_y)),
      .x_arg (q2e_pkg::ARG_W'(car.roll_x)),
      .angle (roll_ang)
   );

   q2e_div u_div (
      .clock (clock),
      .en (en),
      .z (car.z),
      .s28 (s28),
      .axis (axis_val),
      .ovf (axis_ovf)
   );

   // Round every angle to Q13 and clamp it: rotation to 0..2*pi, yaw and roll to +-pi, pitch to +-pi/2.
   always_comb begin
      rot_r = q2e_pkg::q13_round((q2e_pkg::ANG_W + 2)'(half_ang) <<< 1);
      yaw_r = q2e_pkg::q13_round((q2e_pkg::ANG_W + 2)'(yaw_ang));
      pitch_r = q2e_pkg::q13_round((q2e_pkg::ANG_W + 2)'(pitch_ang));
      roll_r = q2e_pkg::q13_round((q2e_pkg::ANG_W + 2)'(roll_ang));

      if (rot_r < 0) begin
         rot_in = '0;
      end else if (rot_r > q2e_pkg::ROT_MAX) begin
         rot_in = 16'(q2e_pkg::ROT_MAX);
      end else begin
         rot_in = 16'(rot_r);
      end

      if (yaw_r > q2e_pkg::YAW_MAX) begin
         yaw_in = 16'(q2e_pkg::YAW_MAX);
      end else if (yaw_r < -q2e_pkg::YAW_MAX) begin
         yaw_in = 16'(-q2e_pkg::YAW_MAX);
      end else begin
         yaw_in = 16'(yaw_r);
      end

      if (roll_r > q2e_pkg::YAW_MAX) begin
         roll_in = 16'(q2e_pkg::YAW_MAX);
      end else if (roll_r < -q2e_pkg::YAW_MAX) begin
         roll_in = 16'(-q2e_pkg::YAW_MAX);
      end else begin
         roll_in = 16'(roll_r);
      end

      if (pitch_r > q2e_pkg::PITCH_MAX) begin
         pitch_in = 15'(q2e_pkg::PITCH_MAX);
      end else if (pitch_r < -q2e_pkg::PITCH_MAX) begin
         pitch_in = 15'(-q2e_pkg::PITCH_MAX);
      end else begin
         pitch_in = 15'(pitch_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mvalid_ff[DEPTH-1];
      end
   end

   // A request that was not answered with angles carries zeros in every other field.
   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= mstat_ff[DEPTH-1];
         if (mstat_ff[DEPTH-1] == q2e_pkg::STATUS_OK) begin
            rot_ff <= rot_in;
            axis_ff <= axis_val;
            ovf_ff <= axis_ovf;
            yaw_ff <= yaw_in;
            pitch_ff <= pitch_in;
            roll_ff <= roll_in;
         end else begin
            rot_ff <= '0;
            axis_ff <= '0;
            ovf_ff <= 1'b0;
            yaw_ff <= '0;
            pitch_ff <= '0;
            roll_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.rotation_angle = rot_ff;
   assign rsp_bus.axis_z = axis_ff;
   assign rsp_bus.axis_overflow = ovf_ff;
   assign rsp_bus.yaw_angle = yaw_ff;
   assign rsp_bus.pitch_angle = pitch_ff;
   assign rsp_bus.roll_angle = roll_ff;

endmodule

// ----- sim/q2e_tb_if.sv -----
// Request and expected response record types shared by the testbench.
package q2e_tb_types;
   typedef struct {
      logic [7:0] cnt;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } pose_type;
   typedef struct {
      logic [1:0] status;
      logic [15:0] rot;
      logic signed [15:0] axis;
      logic ovf;
      logic signed [15:0] yaw;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
   } angles_type;
endpackage

// ----- sim/tb_top.sv -----
// Testbench of the quaternion to Euler angles block with its own angle predictor.
module tb_top;

   localparam longint PI30 = 64'sd3373259426;
   localparam longint HPI30 = 64'sd1686629713;
   localparam longint ONE28 = 64'sd268435456;
   localparam longint NLIM = 64'sd1099511627776;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycles = 0;
   int errors = 0;
   int stall_left = 0;

   q2e_req_if req_bus ();
   q2e_rsp_if rsp_bus ();

   quaternion_to_euler_angles_core u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   // Expected responses, oldest first.
   q2e_tb_types::angles_type pending_angles[$];

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("quaternion_to_euler_angles_core: mismatch");
         $finish;
      end
   end

   // Arctangent table of 2^-i in Q30 radians.
   function automatic longint arctan_step(input int i);
      longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
      return t[i];
   endfunction

   function automatic longint shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint root(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // Vectoring CORDIC arctangent, Q30 radians.
   function automatic longint arctan2(input longint yv, input longint xv);
      longint base, acc, t;
      base = 0;
      acc = 0;
      if (yv == 0) return (xv < 0) ? PI30 : 0;
      if (xv == 0) return (yv > 0) ? HPI30 : -HPI30;
      if (xv < 0) begin
         base = (yv > 0) ? PI30 : -PI30;
         xv = -xv;
         yv = -yv;
      end
      while (xv < NLIM && yv < NLIM && yv > -NLIM) begin
         xv = xv * 2;
         yv = yv * 2;
      end
      for (int i = 0; i < q2e_pkg::CORDIC_ITER; i++) begin
         if (yv > 0) begin
            t = xv + shr(yv, i);
            yv = yv - shr(xv, i);
            acc += arctan_step(i);
         end else begin
            t = xv - shr(yv, i);
            yv = yv + shr(xv, i);
            acc -= arctan_step(i);
         end
         xv = t;
      end
      return base + acc;
   endfunction

   function automatic longint to_q13(input longint v, input longint lo, input longint hi);
      longint r;
      r = (v + 65536) >>> 17;
      return (r < lo) ? lo : ((r > hi) ? hi : r);
   endfunction

   function automatic q2e_tb_types::angles_type predict_angles(
         input q2e_tb_types::pose_type p);
      q2e_tb_types::angles_type e;
      longint x, y, z, w, wc, w28, s28, half, q, mag, a, c;
      x = p.x; y = p.y; z = p.z; w = p.w;
      e = '{default: '0};
      if (p.cnt == 0) begin
         e.status = q2e_pkg::STATUS_NO_MARKER;
         return e;
      end
      if (p.cnt > 2) begin
         e.status = q2e_pkg::STATUS_IGNORED;
         return e;
      end
      e.status = q2e_pkg::STATUS_OK;
      wc = (w < -16384) ? -16384 : ((w > 16384) ? 16384 : w);
      w28 = wc * 16384;
      s28 = root(longint'(ONE28 * ONE28 - w28 * w28));
      half = arctan2(s28, w28);
      e.rot = 16'(to_q13(2 * half, 0, 51472));
      if (s28 == 0) begin
         e.ovf = 1'b1;
         e.axis = (z >= 0) ? 16'sd32767 : -16'sd32768;
      end else begin
         mag = (z < 0) ? -z : z;
         q = (mag * ONE28 + s28 / 2) / s28;
         if (z < 0) begin
            if (q > 32768) begin q = 32768; e.ovf = 1'b1; end
            e.axis = 16'(-q);
         end else begin
            if (q > 32767) begin q = 32767; e.ovf = 1'b1; end
            e.axis = 16'(q);
         end
      end
      e.yaw = 16'(to_q13(arctan2(2 * (y * z + w * x), w * w - x * x - y * y + z * z),
                         -25736, 25736));
      e.roll = 16'(to_q13(arctan2(2 * (x * y + w * z), w * w + x * x - y * y - z * z),
                          -25736, 25736));
      a = 2 * (w * y - x * z);
      a = (a < -ONE28) ? -ONE28 : ((a > ONE28) ? ONE28 : a);
      c = root(longint'(ONE28 * ONE28 - a * a));
      e.pitch = 15'(to_q13(arctan2(a, c), -12868, 12868));
      return e;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      return ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 40))
                                          : int'($urandom_range(0, 3));
   endfunction

   // Sends one request; the expectation is queued when the handshake completes.
   // Valid stays high afterwards so that requests can follow back to back.
   task automatic send_pose(input q2e_tb_types::pose_type p);
      int g;
      g = gap_len();
      repeat (g) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.marker_count <= p.cnt;
      req_bus.quat_x <= p.x;
      req_bus.quat_y <= p.y;
      req_bus.quat_z <= p.z;
      req_bus.quat_w <= p.w;
      do @(posedge clock); while (!req_bus.ready);
      pending_angles.push_back(predict_angles(p));
   endtask

   function automatic q2e_tb_types::pose_type make_pose(input int c, input int x, input int y,
                                                        input int z, input int w);
      q2e_tb_types::pose_type p;
      p.cnt = 8'(c); p.x = 16'(x); p.y = 16'(y); p.z = 16'(z); p.w = 16'(w);
      return p;
   endfunction

   // Receiver: random stalls, a few of them long, with stretches of none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (cycles % 2000 < 500) begin
         rsp_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 59) == 0) begin
         stall_left <= int'($urandom_range(10, 40));
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compares every accepted response with the oldest expectation.
   always @(posedge clock) begin
      q2e_tb_types::angles_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, rsp_bus.status);
            errors++;
         end else begin
            e = pending_angles.pop_front();
            if (e.status !== rsp_bus.status || e.rot !== rsp_bus.rotation_angle ||
                e.axis !== rsp_bus.axis_z || e.ovf !== rsp_bus.axis_overflow ||
                e.yaw !== rsp_bus.yaw_angle || e.pitch !== rsp_bus.pitch_angle ||
                e.roll !== rsp_bus.roll_angle) begin
               $display("%0t: expected st %0d rot %0d axis %0d ovf %0d yaw %0d %s %0d %s %0d",
                        $time, e.status, e.rot, e.axis, e.ovf, e.yaw, "pitch", e.pitch,
                        "roll", e.roll);
               $display("%0t: actual   st %0d rot %0d axis %0d ovf %0d yaw %0d %s %0d %s %0d",
                        $time, rsp_bus.status, rsp_bus.rotation_angle, rsp_bus.axis_z,
                        rsp_bus.axis_overflow, rsp_bus.yaw_angle, "pitch",
                        rsp_bus.pitch_angle, "roll", rsp_bus.roll_angle);
               errors++;
            end
         end
      end
   end

   // Extremes, marker counts, singular w and clamped asin arguments.
   task automatic test_directed();
      send_pose(make_pose(0, 100, 200, 300, 400));
      send_pose(make_pose(3, 100, 200, 300, 400));
      send_pose(make_pose(255, -1, -1, -1, -1));
      send_pose(make_pose(1, 0, 0, 0, 16384));
      send_pose(make_pose(2, 0, 0, -5, -16384));
      send_pose(make_pose(1, 0, 0, 0, 0));
      send_pose(make_pose(1, 32767, 32767, 32767, 32767));
      send_pose(make_pose(2, -32768, -32768, -32768, -32768));
      send_pose(make_pose(1, 0, 0, 32767, 100));
      send_pose(make_pose(1, 0, 0, -32768, 100));
      send_pose(make_pose(1, 0, 16384, 0, 16384));
      send_pose(make_pose(1, 16384, 0, 16384, 0));
      send_pose(make_pose(2, 11585, 0, 0, 11585));
      send_pose(make_pose(1, 0, 0, 11585, -11585));
      send_pose(make_pose(1, 0, 0, 0, -16384));
      send_pose(make_pose(2, 0, 0, 0, 32767));
      send_pose(make_pose(1, 16384, 0, 0, 0));
      send_pose(make_pose(1, 0, -16384, 0, 0));
   endtask

   // Random poses: mostly with components within plus or minus one, some raw full-range ones.
   task automatic test_random(input int n);
      q2e_tb_types::pose_type p;
      int c;
      for (int i = 0; i < n; i++) begin
         c = int'($urandom_range(0, 19));
         p.cnt = (c < 2) ? 8'($urandom_range(0, 255)) : ((c < 11) ? 8'd1 : 8'd2);
         if ($urandom_range(0, 3) == 0) begin
            p.x = 16'($urandom); p.y = 16'($urandom);
            p.z = 16'($urandom); p.w = 16'($urandom);
         end else begin
            p.x = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            p.y = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            p.z = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            p.w = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         end
         send_pose(p);
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.marker_count = '0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.quat_w = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1950);
      req_bus.valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      // Allow any stray late response to show up.
      repeat (q2e_pkg::PIPE_DEPTH + 20) @(posedge clock);
      if (errors == 0) begin
         $display("quaternion_to_euler_angles_core: match");
      end else begin
         $display("quaternion_to_euler_angles_core: mismatch");
      end
      $finish;
   end

endmodule
